FILE: rtl/dvrtp_pkg.sv
`default_nettype none

package dvrtp_pkg;

  // dif block geometry
  localparam int unsigned DIF_BYTES = 80;
  localparam logic [6:0] DIF_LAST = 7'(DIF_BYTES - 1);

  // payload modes
  localparam logic [1:0] MODE_VIDEO   = 2'd0;
  localparam logic [1:0] MODE_BUNDLED = 2'd1;
  localparam logic [1:0] MODE_AUDIO   = 2'd2;

  // block type codes from the top three bits of a block's first byte
  localparam logic [2:0] TYPE_LAST_ALWAYS = 3'd2;
  localparam logic [2:0] TYPE_AUDIO       = 3'd3;
  localparam logic [2:0] TYPE_VIDEO       = 3'd4;

  // configuration register indexes
  localparam logic [0:0] CFG_PAYLOAD_MODE = 1'b0;
  localparam logic [0:0] CFG_MAX_BLOCKS   = 1'b1;

  // configuration reset values
  localparam logic [1:0] MODE_RESET       = MODE_VIDEO;
  localparam logic [7:0] MAX_BLOCKS_RESET = 8'd17;

  // one result item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       packet_end;
    logic       marker_bit;
  } result_t;

  // decide from the first byte of a block whether the block is carried
  function automatic logic block_kept(input logic [7:0] first_byte, input logic [1:0] mode);
    logic [2:0] kind;
    logic       keep;
    kind = first_byte[7:5];
    if (kind <= TYPE_LAST_ALWAYS) begin
      keep = 1'b1;
    end else if (kind == TYPE_AUDIO) begin
      keep = (mode != MODE_VIDEO);
    end else if (kind == TYPE_VIDEO) begin
      keep = (mode != MODE_AUDIO);
    end else begin
      keep = 1'b0;
    end
    return keep;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dvrtp_out_buf.sv
`default_nettype none

module dvrtp_out_buf
  import dvrtp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    res_valid_i,
  input  wire result_t res_i,
  output logic         full_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      out_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    take;

  // downstream transfer of the head entry
  assign take = out_valid_q && !out_stall_i;

  // two-entry buffer: head register plus skid register
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_d = res_valid_i;
      out_d       = res_i;
    end else if (res_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

FILE: rtl/dv_dif_block_rtp_packetizer_top.sv
// results: a byte's result is registered in the head register, or in the skid register
// while the head stalls; throughput: one byte per cycle while in_stall_o is low, set by the
// single registered pass over the block counters and the two-entry output buffer
// reset: counters and frame state clear, payload mode goes to video only,
// blocks per packet to 17, and the output buffer empties
`default_nettype none

module dv_dif_block_rtp_packetizer_top
  import dvrtp_pkg::*;
#(
  parameter int MAX_FRAME_BLOCKS = 4095
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  // frame byte input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_start_i,
  input  wire logic [11:0] frame_blocks_i,
  // payload output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       payload_byte_o,
  output logic             byte_valid_o,
  output logic             packet_end_o,
  output logic             marker_bit_o
);

  logic [1:0]  mode_q;
  logic [7:0]  max_blocks_q;
  logic [6:0]  bib_q, bib_d;
  logic [11:0] rem_q, rem_d;
  logic [7:0]  filled_q, filled_d;
  logic        keep_q, keep_d;
  logic        in_frame_q, in_frame_d;

  logic        accept;
  logic        buf_full;
  logic [11:0] blocks_sat;
  logic [6:0]  bib_e;
  logic [11:0] rem_e;
  logic [7:0]  filled_e, filled_inc;
  logic        keep_e, in_frame_e;
  logic        close, marker;
  logic        res_valid;
  result_t     res, out_res;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = buf_full;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_RESET;
      max_blocks_q <= MAX_BLOCKS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAYLOAD_MODE: mode_q       <= cfg_data_i[1:0];
        CFG_MAX_BLOCKS:   max_blocks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // block count clipped to the frame limit
  assign blocks_sat = (32'(frame_blocks_i) > MAX_FRAME_BLOCKS) ?
                      12'(MAX_FRAME_BLOCKS) : frame_blocks_i;

  // state as seen by this byte, restarted on a frame start
  always_comb begin
    if (frame_start_i) begin
      bib_e      = '0;
      rem_e      = blocks_sat;
      filled_e   = '0;
      keep_e     = 1'b0;
      in_frame_e = (blocks_sat != '0);
    end else begin
      bib_e      = bib_q;
      rem_e      = rem_q;
      filled_e   = filled_q;
      keep_e     = keep_q;
      in_frame_e = in_frame_q;
    end
  end

  // per-byte step: block type, counters, packet close and marker
  always_comb begin
    bib_d      = bib_e;
    rem_d      = rem_e;
    filled_d   = filled_e;
    keep_d     = keep_e;
    in_frame_d = in_frame_e;
    filled_inc = filled_e;
    close      = 1'b0;
    marker     = 1'b0;
    if (in_frame_e) begin
      if (bib_e == '0) begin
        keep_d = block_kept(frame_byte_i, mode_q);
      end
      if (bib_e >= DIF_LAST) begin
        bib_d = '0;
        rem_d = (rem_e != '0) ? rem_e - 12'd1 : '0;
        if (keep_d && filled_e != 8'hFF) begin
          filled_inc = filled_e + 8'd1;
        end
        close      = (filled_inc >= max_blocks_q) || (rem_d == '0);
        marker     = close && (rem_d < 12'd2);
        filled_d   = close ? '0 : filled_inc;
        in_frame_d = (rem_d != '0);
      end else begin
        bib_d = bib_e + 7'd1;
      end
    end
  end

  // result item for this byte
  always_comb begin
    res.payload_byte = keep_d ? frame_byte_i : 8'd0;
    res.byte_valid   = keep_d;
    res.packet_end   = close;
    res.marker_bit   = marker;
  end
  assign res_valid = accept && in_frame_e && (keep_d || close);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bib_q      <= '0;
      rem_q      <= '0;
      filled_q   <= '0;
      keep_q     <= 1'b0;
      in_frame_q <= 1'b0;
    end else if (accept) begin
      bib_q      <= bib_d;
      rem_q      <= rem_d;
      filled_q   <= filled_d;
      keep_q     <= keep_d;
      in_frame_q <= in_frame_d;
    end
  end

  // result register and skid
  dvrtp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign payload_byte_o = out_res.payload_byte;
  assign byte_valid_o   = out_res.byte_valid;
  assign packet_end_o   = out_res.packet_end;
  assign marker_bit_o   = out_res.marker_bit;

endmodule

`default_nettype wire

FILE: rtl/dvrtp_checker.sv
`default_nettype none

module dvrtp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] payload_byte_o,
  input wire logic       byte_valid_o,
  input wire logic       packet_end_o,
  input wire logic       marker_bit_o
);

  // marker only on a closing item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && marker_bit_o) |-> packet_end_o)
    else $error("marker without packet end");

  // an item with no data must close a packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (packet_end_o && payload_byte_o == 8'd0))
    else $error("end-only item malformed");

  // a new result needs a byte transfer in the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without input transfer");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(payload_byte_o) && $stable(byte_valid_o) &&
       $stable(packet_end_o) && $stable(marker_bit_o)))
    else $error("stalled result changed");

endmodule

bind dv_dif_block_rtp_packetizer_top dvrtp_checker u_dvrtp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .payload_byte_o (payload_byte_o),
  .byte_valid_o   (byte_valid_o),
  .packet_end_o   (packet_end_o),
  .marker_bit_o   (marker_bit_o)
);

`default_nettype wire

FILE: tb/sv/dv_dif_block_rtp_packetizer_top_tb.sv
`timescale 1ns / 100ps

module dv_dif_block_rtp_packetizer_top_tb;
  import dvrtp_pkg::*;

  localparam int FRAME_CAP = 4095;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // one byte transfer towards the block
  typedef struct {
    logic [7:0]  b;
    logic        s;
    logic [11:0] n;
  } byte_xfer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = CFG_PAYLOAD_MODE;
  logic [7:0]  cfg_data_i = 8'h00;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  frame_byte_i = 8'h00;
  logic        frame_start_i = 1'b0;
  logic [11:0] frame_blocks_i = 12'h000;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  payload_byte_o;
  logic        byte_valid_o;
  logic        packet_end_o;
  logic        marker_bit_o;

  // pending frame bytes and the payload still owed by the block
  byte_xfer_t pending_bytes[$];
  result_t    payload_due[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;

  // packetizer prediction: configuration copy and frame state
  logic [1:0]  mode_q = MODE_RESET;
  logic [7:0]  maxblk_q = MAX_BLOCKS_RESET;
  logic [6:0]  frame_pos = '0;
  logic [11:0] blocks_left = '0;
  logic [7:0]  packet_blocks = '0;
  logic        block_carried = 1'b0;
  logic        frame_open = 1'b0;

  dv_dif_block_rtp_packetizer_top #(
    .MAX_FRAME_BLOCKS(FRAME_CAP)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frame_byte_i   (frame_byte_i),
    .frame_start_i  (frame_start_i),
    .frame_blocks_i (frame_blocks_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_o (payload_byte_o),
    .byte_valid_o   (byte_valid_o),
    .packet_end_o   (packet_end_o),
    .marker_bit_o   (marker_bit_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // block type decides whether a dif block goes into the payload
  function automatic logic carried(input logic [7:0] first);
    logic [2:0] kind;
    kind = first[7:5];
    case (kind)
      TYPE_AUDIO: return mode_q != MODE_VIDEO;
      TYPE_VIDEO: return mode_q != MODE_AUDIO;
      default:    return kind <= TYPE_LAST_ALWAYS;
    endcase
  endfunction

  // advance the frame state by one accepted byte, queue any payload it causes
  task automatic take_byte(input logic [7:0] b, input logic s, input logic [11:0] n);
    logic    closes;
    logic    mark;
    logic    carry;
    result_t r;
    closes = 1'b0;
    mark = 1'b0;
    if (s) begin
      blocks_left = (n > FRAME_CAP) ? 12'(FRAME_CAP) : n;
      packet_blocks = '0;
      frame_pos = '0;
      block_carried = 1'b0;
      frame_open = (blocks_left != 0);
    end
    if (frame_open) begin
      if (frame_pos == 0) begin
        block_carried = carried(b);
      end
      carry = block_carried;
      if (frame_pos == DIF_LAST) begin
        frame_pos = '0;
        if (blocks_left != 0) begin
          blocks_left = blocks_left - 1'b1;
        end
        if (block_carried && packet_blocks != 8'hFF) begin
          packet_blocks = packet_blocks + 1'b1;
        end
        closes = (packet_blocks >= maxblk_q) || (blocks_left == 0);
        if (closes) begin
          mark = (blocks_left < 2);
          packet_blocks = '0;
        end
        if (blocks_left == 0) begin
          frame_open = 1'b0;
        end
      end else begin
        frame_pos = frame_pos + 1'b1;
      end
      if (carry || closes) begin
        r.payload_byte = carry ? b : 8'h00;
        r.byte_valid = carry;
        r.packet_end = closes;
        r.marker_bit = mark;
        payload_due.push_back(r);
      end
    end
  endtask

  // byte driver: next byte offered once the current one has transferred
  always @(posedge clk_i) begin : drive_bytes
    byte_xfer_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_bytes.pop_front();
        in_valid_i <= 1'b1;
        frame_byte_i <= nxt.b;
        frame_start_i <= nxt.s;
        frame_blocks_i <= nxt.n;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: check payload transfers, predict from byte transfers
  always @(posedge clk_i) begin : watch_payload
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {payload_byte_o, byte_valid_o, packet_end_o, marker_bit_o};
        if (payload_due.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got byte %02h valid %0b end %0b marker %0b",
                   $time, got.payload_byte, got.byte_valid, got.packet_end, got.marker_bit);
          fail_count++;
        end else begin
          want = payload_due.pop_front();
          if (got.payload_byte !== want.payload_byte) begin
            $display("%0t: payload_byte expected %02h got %02h",
                     $time, want.payload_byte, got.payload_byte);
            fail_count++;
          end
          if (got.byte_valid !== want.byte_valid) begin
            $display("%0t: byte_valid expected %0b got %0b",
                     $time, want.byte_valid, got.byte_valid);
            fail_count++;
          end
          if (got.packet_end !== want.packet_end) begin
            $display("%0t: packet_end expected %0b got %0b",
                     $time, want.packet_end, got.packet_end);
            fail_count++;
          end
          if (got.marker_bit !== want.marker_bit) begin
            $display("%0t: marker_bit expected %0b got %0b",
                     $time, want.marker_bit, got.marker_bit);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        take_byte(frame_byte_i, frame_start_i, frame_blocks_i);
      end
    end
  end

  // register write while the block is idle
  task automatic cfg_write(input logic [0:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_PAYLOAD_MODE) begin
      mode_q = val[1:0];
    end else begin
      maxblk_q = val;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // queue one frame (or loose bytes when opens is low)
  task automatic queue_frame(input logic opens, input logic [11:0] nb, input int nbytes);
    byte_xfer_t x;
    int         k;
    for (k = 0; k < nbytes; k++) begin
      x.s = opens && (k == 0);
      x.n = x.s ? nb : 12'($urandom);
      x.b = 8'($urandom);
      pending_bytes.push_back(x);
    end
  endtask

  // mostly whole short frames, some cut short, empty frames and loose bytes
  task automatic fill_random(input int target);
    int          counted;
    int          pick;
    int          len;
    logic [11:0] nb;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        nb = 12'($urandom_range(1, 3));
        queue_frame(1'b1, nb, nb * 80 + $urandom_range(0, 3));
        counted += nb * 80;
      end else if (pick < 80) begin
        nb = 12'($urandom);
        if (nb < 4) begin
          nb = 12'hFFF;
        end
        len = $urandom_range(1, 170);
        queue_frame(1'b1, nb, len);
        counted += len;
      end else if (pick < 90) begin
        queue_frame(1'b1, 12'h000, $urandom_range(1, 4));
      end else begin
        queue_frame(1'b0, 12'h000, $urandom_range(1, 3));
      end
    end
  endtask

  // hold until every byte has gone in and every payload transfer has come out
  task automatic wait_settled();
    while (pending_bytes.size() != 0 || in_valid_i || payload_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // stimulus sequence
  initial begin : run_phases
    logic [1:0] mode_plan [8];
    logic [7:0] blocks_plan [8];
    byte_xfer_t x;
    int         ph;
    int         k;
    mode_plan = '{MODE_VIDEO, MODE_BUNDLED, MODE_AUDIO, MODE_SPARE,
                  MODE_BUNDLED, MODE_VIDEO, MODE_AUDIO, MODE_SPARE};
    blocks_plan = '{8'd17, 8'd1, 8'd255, 8'd0, 8'd2, 8'd3,
                    8'($urandom_range(4, 254)), 8'd1};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: loose bytes while idle, an empty frame, a huge frame cut short
    x = '{8'hFF, 1'b0, 12'hFFF};
    pending_bytes.push_back(x);
    x = '{8'h00, 1'b0, 12'h000};
    pending_bytes.push_back(x);
    x = '{8'h80, 1'b1, 12'h000};
    pending_bytes.push_back(x);
    x = '{8'h60, 1'b0, 12'h001};
    pending_bytes.push_back(x);
    x = '{8'h80, 1'b1, 12'hFFF};
    pending_bytes.push_back(x);
    for (k = 0; k < 19; k++) begin
      x = '{8'(k * 13 + 1), 1'b0, 12'(k)};
      pending_bytes.push_back(x);
    end
    wait_settled();

    for (ph = 0; ph < 8; ph++) begin
      cfg_write(CFG_PAYLOAD_MODE, {6'b0, mode_plan[ph]});
      cfg_write(CFG_MAX_BLOCKS, blocks_plan[ph]);
      @(negedge clk_i);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      // one batch, then a full drain before the next phase
      fill_random(80);
      wait_settled();
    end

    if (payload_due.size() != 0) begin
      $display("%0t: %0d payload transfers never arrived", $time, payload_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
